[rtl/core/lpt_pkg.sv]
// types, constants and sequencer program for the patience-sorting tails unit
package lpt_pkg;

   localparam int MAX_LEN = 64;
   localparam int IDX_W   = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
   localparam int CNT_W   = $clog2(MAX_LEN + 1);
   localparam int RUN_W   = 7;

   typedef struct packed {
      logic signed [31:0] sample;
      logic               start_req;
   } req_type;

   typedef struct packed {
      logic [RUN_W-1:0] run_length;
      logic             overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      STEP_ACCEPT,
      STEP_PROBE,
      STEP_COMPARE,
      STEP_COMMIT
   } step_type;

   typedef enum logic [1:0] {
      OP_ACCEPT,
      OP_PROBE,
      OP_COMPARE,
      OP_COMMIT
   } op_type;

   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_REQ,
      COND_DONE,
      COND_RSP_FREE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type jump_true;
      step_type jump_false;
   } ctrl_word_type;

   function automatic ctrl_word_type ctrl_rom(step_type step);
      ctrl_word_type cw;
      unique case (step)
         STEP_ACCEPT:  cw = '{OP_ACCEPT,  COND_REQ,      STEP_PROBE,  STEP_ACCEPT};
         STEP_PROBE:   cw = '{OP_PROBE,   COND_DONE,     STEP_COMMIT, STEP_COMPARE};
         STEP_COMPARE: cw = '{OP_COMPARE, COND_ALWAYS,   STEP_PROBE,  STEP_PROBE};
         STEP_COMMIT:  cw = '{OP_COMMIT,  COND_RSP_FREE, STEP_ACCEPT, STEP_COMMIT};
         default:      cw = '{OP_ACCEPT,  COND_REQ,      STEP_PROBE,  STEP_ACCEPT};
      endcase
      return cw;
   endfunction

endpackage

[rtl/core/lis_length_patience_tails_unit.sv]
// longest strictly increasing subsequence length by patience sorting, microcoded top level
//
// Each item is handled in steps: one step accepts the item, then each binary-search probe of
// the tails memory (at most clog2(MAX_LEN+1) probes for a full store of 64) takes one step to
// read the tails memory through its output register and one to compare and narrow the range;
// a final check ends the search and one step writes the tail and loads the result register.
// A new item is taken while the previous result still waits in that register; the commit
// step holds only if that register is still occupied. start_req empties the store by
// clearing the count, so there is no clearing pass after reset.
module lis_length_patience_tails_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lpt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lpt_pkg::rsp_type rsp_data
);

   logic signed [31:0]          tails_mem [lpt_pkg::MAX_LEN];
   logic signed [31:0]          rd_ff;
   logic signed [31:0]          sample_ff, sample_in;
   logic [lpt_pkg::CNT_W-1:0]   lo_ff, lo_in;
   logic [lpt_pkg::CNT_W-1:0]   hi_ff, hi_in;
   logic [lpt_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [lpt_pkg::CNT_W-1:0]   mid;
   logic [lpt_pkg::CNT_W-1:0]   mid_ff, mid_in;
   logic                        overflowed_ff, overflowed_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   lpt_pkg::rsp_type            rsp_ff, rsp_in;
   lpt_pkg::step_type           step_ff, step_in;
   lpt_pkg::ctrl_word_type      cw;
   logic                        cond_true;
   logic                        rsp_free;
   logic                        wr_en;
   logic                        drop;

   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (cw.op == lpt_pkg::OP_ACCEPT);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= lpt_pkg::STEP_ACCEPT;
         count_ff      <= '0;
         overflowed_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         step_ff       <= step_in;
         count_ff      <= count_in;
         overflowed_ff <= overflowed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      sample_ff <= sample_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      rsp_ff    <= rsp_in;
   end

   // tails memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tails_mem[lo_ff[lpt_pkg::IDX_W-1:0]] <= sample_ff;
      end
      rd_ff <= tails_mem[mid[lpt_pkg::IDX_W-1:0]];
   end

   always_comb begin
      cw            = lpt_pkg::ctrl_rom(step_ff);
      sample_in     = sample_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      count_in      = count_ff;
      overflowed_in = overflowed_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      wr_en         = 1'b0;
      drop          = 1'b0;

      unique case (cw.cond)
         lpt_pkg::COND_ALWAYS:   cond_true = 1'b1;
         lpt_pkg::COND_REQ:      cond_true = req_valid;
         lpt_pkg::COND_DONE:     cond_true = (lo_ff >= hi_ff);
         lpt_pkg::COND_RSP_FREE: cond_true = rsp_free;
         default:                cond_true = 1'b0;
      endcase

      step_in = cond_true ? cw.jump_true : cw.jump_false;

      unique case (cw.op)
         lpt_pkg::OP_ACCEPT: begin
            if (cond_true) begin
               sample_in = req_data.sample;
               lo_in     = '0;
               if (req_data.start_req) begin
                  count_in      = '0;
                  overflowed_in = 1'b0;
                  hi_in         = '0;
               end else begin
                  hi_in = count_ff;
               end
            end
         end
         lpt_pkg::OP_PROBE: begin
            mid_in = mid;
         end
         lpt_pkg::OP_COMPARE: begin
            if (rd_ff < sample_ff) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
         end
         lpt_pkg::OP_COMMIT: begin
            if (cond_true) begin
               if (lo_ff < count_ff) begin
                  wr_en = 1'b1;
               end else if (count_ff < lpt_pkg::CNT_W'(lpt_pkg::MAX_LEN)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  drop          = 1'b1;
                  overflowed_in = 1'b1;
               end
               rsp_in.run_length = lpt_pkg::RUN_W'(count_in);
               rsp_in.overflow   = drop;
               rsp_valid_in      = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lpt_pkg::CNT_W'(lpt_pkg::MAX_LEN))
      else $error("tail count beyond capacity");

   a_range_order: assert property (@(posedge clock) disable iff (reset)
      (step_ff == lpt_pkg::STEP_PROBE || step_ff == lpt_pkg::STEP_COMPARE) |-> lo_ff <= hi_ff)
      else $error("search range inverted");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      drop |-> count_ff == lpt_pkg::CNT_W'(lpt_pkg::MAX_LEN))
      else $error("item dropped while store not full");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.start_req) |=> count_ff == '0)
      else $error("start item did not empty the store");

   a_result_on_commit: assert property (@(posedge clock) disable iff (reset)
      (step_ff == lpt_pkg::STEP_COMMIT && rsp_free) |=> rsp_valid_ff)
      else $error("commit did not load a result");

endmodule

[verif/tb.sv]
// self-checking testbench for the patience-sorting lis length unit: predicted lengths vs. dut
`timescale 1ns / 1ps

module tb;

   localparam int STUCK_LIMIT = 2000;
   localparam int PRINT_CAP   = 100;
   localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   lpt_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   lpt_pkg::rsp_type rsp_data;

   lis_length_patience_tails_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // predictor state
   logic signed [31:0] tail_store [lpt_pkg::MAX_LEN];
   int unsigned        tail_count = 0;
   lpt_pkg::rsp_type   expected_lengths [$];

   int  mismatches = 0;
   int  stuck_cycles = 0;
   bit  idle_on = 1'b1;
   int  rx_hold_len = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic lpt_pkg::rsp_type predict_length(lpt_pkg::req_type item);
      lpt_pkg::rsp_type r;
      int unsigned      lo;
      int unsigned      hi;
      int unsigned      mid;
      if (item.start_req) begin
         tail_count = 0;
      end
      lo = 0;
      hi = tail_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if ($signed(tail_store[mid]) < $signed(item.sample)) begin
            lo = mid + 1;
         end else begin
            hi = mid;
         end
      end
      r.overflow = 1'b0;
      if (lo < tail_count) begin
         tail_store[lo] = item.sample;
      end else if (tail_count < lpt_pkg::MAX_LEN) begin
         tail_store[tail_count] = item.sample;
         tail_count++;
      end else begin
         r.overflow = 1'b1;
      end
      r.run_length = lpt_pkg::RUN_W'(tail_count);
      return r;
   endfunction

   function automatic lpt_pkg::req_type make_req(logic signed [31:0] s, logic st);
      lpt_pkg::req_type r;
      r.sample    = s;
      r.start_req = st;
      return r;
   endfunction

   function automatic logic signed [31:0] edge_value(int sel);
      case (sel)
         0:       return S_MIN;
         1:       return S_MIN + 1;
         2:       return -32'sd1;
         3:       return 32'sd0;
         4:       return 32'sd1;
         5:       return S_MAX - 1;
         default: return S_MAX;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < PRINT_CAP) begin
         $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
      end
      mismatches++;
   endtask

   task automatic send_item(input lpt_pkg::req_type item);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      expected_lengths.insert(expected_lengths.size(), predict_length(item));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_lengths.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      lpt_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_lengths.size() == 0) begin
            report_mismatch("unexpected item, run_length", int'(rsp_data.run_length), -1);
         end else begin
            want = expected_lengths.pop_front();
            if (rsp_data.run_length !== want.run_length) begin
               report_mismatch("run_length", int'(rsp_data.run_length),
                               int'(want.run_length));
            end
            if (rsp_data.overflow !== want.overflow) begin
               report_mismatch("overflow", int'(rsp_data.overflow), int'(want.overflow));
            end
         end
      end
   end

   // receiver
   initial begin
      int hold;
      forever begin
         if (rx_hold_len > 0) begin
            hold = rx_hold_len;
            rx_hold_len = 0;
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   task automatic test_directed();
      send_item(make_req(32'sd0, 1'b0));
      send_item(make_req(32'sd0, 1'b0));
      send_item(make_req(-32'sd1, 1'b0));
      send_item(make_req(32'sd1, 1'b0));
      send_item(make_req(S_MAX, 1'b0));
      send_item(make_req(S_MAX, 1'b0));
      send_item(make_req(S_MIN, 1'b0));
      send_item(make_req(S_MIN + 1, 1'b0));
      send_item(make_req(S_MAX, 1'b1));
      send_item(make_req(S_MIN, 1'b0));
      send_item(make_req(S_MIN, 1'b0));
      send_item(make_req(-32'sd1, 1'b0));
      send_item(make_req(32'sd0, 1'b0));
      send_item(make_req(S_MAX - 1, 1'b0));
      send_item(make_req(S_MAX, 1'b0));
      send_item(make_req(32'sd5, 1'b1));
      send_item(make_req(32'sd5, 1'b0));
      send_item(make_req(32'sd6, 1'b0));
      send_item(make_req(32'sd4, 1'b0));
      send_item(make_req(32'sh5555_5555, 1'b0));
      send_item(make_req(32'shAAAA_AAAA, 1'b0));
   endtask

   task automatic test_store_full();
      int i;
      for (i = 0; i < lpt_pkg::MAX_LEN; i++) begin
         send_item(make_req(S_MIN + (i << 25), i == 0));
      end
      send_item(make_req(S_MAX, 1'b0));
      send_item(make_req(S_MAX, 1'b0));
      send_item(make_req(32'sd0, 1'b0));
      send_item(make_req(S_MIN, 1'b0));
      send_item(make_req(S_MAX - 1, 1'b0));
      send_item(make_req(S_MAX, 1'b0));
      send_item(make_req(32'sd7, 1'b1));
   endtask

   task automatic test_random_runs(input int n_items);
      int                 sent;
      int                 run_len;
      int                 shape;
      int                 i;
      logic signed [31:0] val;
      sent = 0;
      while (sent < n_items) begin
         shape   = $urandom_range(0, 4);
         run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 80)
                                               : $urandom_range(1, 24);
         val = (shape == 1) ? S_MIN + $urandom_range(0, 1 << 20) : $urandom;
         for (i = 0; i < run_len; i++) begin
            case (shape)
               0:       val = $urandom;
               1:       val = val + $urandom_range(0, 1 << 20);
               2:       val = $urandom_range(0, 7) - 4;
               3:       val = val - $urandom_range(0, 1 << 20);
               default: val = edge_value($urandom_range(0, 6));
            endcase
            send_item(make_req(val, (i == 0 && $urandom_range(0, 7) != 0)
                                    || $urandom_range(0, 39) == 0));
            sent++;
         end
      end
   endtask

   task automatic test_output_stall();
      int i;
      rx_hold_len = 300;
      for (i = 0; i < 12; i++) begin
         send_item(make_req($urandom, i == 0));
      end
      wait_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_store_full();
      test_random_runs(480);
      test_output_stall();
      idle_on = 1'b0;
      test_random_runs(120);
      wait_drained();
      if (mismatches == 0 && expected_lengths.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
